// ===== rtl/core/pkfwrl_pkg.sv =====
package pkfwrl_pkg;

   localparam int TIME_W   = 48;
   localparam int KEY_W    = 64;
   localparam int COUNT_W  = 16;
   localparam int LEN_W    = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int SLOT_OUT_W = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLOBAL_LIMIT = 2'd0,
      CSR_GLOBAL_LEN   = 2'd1,
      CSR_PEER_LIMIT   = 2'd2,
      CSR_PEER_LEN     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT      = 2'd0,
      VERDICT_GLOBAL_REJ  = 2'd1,
      VERDICT_PEER_REJ    = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GCHECK,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [KEY_W-1:0]  peer_word_0;
      logic [KEY_W-1:0]  peer_word_1;
      logic [KEY_W-1:0]  peer_word_2;
      logic [KEY_W-1:0]  peer_word_3;
   } req_type;

   typedef struct packed {
      logic [1:0]            verdict;
      logic [SLOT_OUT_W-1:0] slot_used;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key_w0;
      logic [KEY_W-1:0]   key_w1;
      logic [KEY_W-1:0]   key_w2;
      logic [KEY_W-1:0]   key_w3;
      logic [TIME_W-1:0]  win_start;
      logic [COUNT_W-1:0] count;
   } slot_type;

   typedef struct packed {
      logic               found;
      logic [TIME_W-1:0]  win_start;
      logic [COUNT_W-1:0] count;
   } match_type;

endpackage

// ===== rtl/core/per_key_fixed_window_rate_limiter.sv =====
// Per-key fixed-window rate limiter. Pulse start while busy is low to
// transfer one request; exactly one result appears on rsp_data for one
// cycle with rsp_valid, after the global window check (ST_GCHECK), one
// turn of the ring of slot cells past the single key comparator
// (ST_SCAN) and the update of the chosen slot (ST_DECIDE). A globally
// rejected request skips the scan and its result is registered straight
// from the global check. busy drops in the cycle the result strobe is
// shown. The result cannot be stalled; capture it in the cycle it is
// shown. Configuration writes through csr_* take effect at once and
// belong in idle periods.
module per_key_fixed_window_rate_limiter
   import pkfwrl_pkg::*;
#(
   parameter int PEER_SLOTS = 64
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int UW = $clog2(PEER_SLOTS + 1);

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [COUNT_W-1:0]    glim_ff, glim_in, plim_ff, plim_in;
   logic [LEN_W-1:0]      glen_ff, glen_in, plen_ff, plen_in;
   logic [TIME_W-1:0]     gstart_ff, gstart_in;
   logic [COUNT_W-1:0]    gcount_ff, gcount_in;
   logic [UW-1:0]         used_ff, used_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   slot_type              cell_q [PEER_SLOTS];
   logic                  shift_en, wr_en;
   slot_type              wr_data;
   logic [IW-1:0]         wr_idx;

   logic                  scan_clear, scan_live;
   match_type             match;
   logic [IW-1:0]         match_idx, evict_idx;

   logic [TIME_W-1:0]     g_elapsed, p_elapsed, p_start;
   logic [COUNT_W-1:0]    g_count_eff, p_count;
   logic                  g_reject, p_reject;

   genvar gi;
   generate
      for (gi = 0; gi < PEER_SLOTS; gi++) begin : g_ring
         pkfwrl_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .shift_in (cell_q[(gi + 1) % PEER_SLOTS]),
            .wr_en    (wr_en && wr_idx == IW'(gi)),
            .wr_data  (wr_data),
            .slot_q   (cell_q[gi])
         );
      end
   endgenerate

   assign scan_live = UW'(idx_ff) < used_ff;

   pkfwrl_scan #(.IW(IW)) u_scan (
      .clock     (clock),
      .clear     (scan_clear),
      .step      (shift_en),
      .live      (scan_live),
      .head_idx  (idx_ff),
      .head      (cell_q[0]),
      .req       (req_ff),
      .match     (match),
      .match_idx (match_idx),
      .evict_idx (evict_idx)
   );

   always_comb begin
      g_elapsed   = req_ff.now_ms - gstart_ff;
      g_count_eff = (g_elapsed >= TIME_W'(glen_ff)) ? '0 : gcount_ff;
      g_reject    = g_count_eff >= glim_ff;

      if (match.found) begin
         wr_idx  = match_idx;
         p_start = match.win_start;
         p_count = match.count;
      end else begin
         wr_idx  = (used_ff < UW'(PEER_SLOTS)) ? IW'(used_ff) : evict_idx;
         p_start = req_ff.now_ms;
         p_count = '0;
      end
      p_elapsed = req_ff.now_ms - p_start;
      if (p_elapsed >= TIME_W'(plen_ff)) begin
         p_start = req_ff.now_ms;
         p_count = '0;
      end
      p_reject = p_count >= plim_ff;

      wr_data.key_w0    = req_ff.peer_word_0;
      wr_data.key_w1    = req_ff.peer_word_1;
      wr_data.key_w2    = req_ff.peer_word_2;
      wr_data.key_w3    = req_ff.peer_word_3;
      wr_data.win_start = p_start;
      wr_data.count     = p_reject ? p_count : p_count + COUNT_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      gstart_in    = gstart_ff;
      gcount_in    = gcount_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      shift_en     = 1'b0;
      wr_en        = 1'b0;
      scan_clear   = 1'b0;

      glim_in = glim_ff;
      glen_in = glen_ff;
      plim_in = plim_ff;
      plen_in = plen_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GLOBAL_LIMIT: glim_in = csr_data[COUNT_W-1:0];
            CSR_GLOBAL_LEN:   glen_in = csr_data;
            CSR_PEER_LIMIT:   plim_in = csr_data[COUNT_W-1:0];
            CSR_PEER_LEN:     plen_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_GCHECK;
            end
         end
         ST_GCHECK: begin
            if (g_elapsed >= TIME_W'(glen_ff)) begin
               gstart_in = req_ff.now_ms;
               gcount_in = '0;
            end
            if (g_reject) begin
               rsp_valid_in      = 1'b1;
               rsp_in.verdict    = VERDICT_GLOBAL_REJ;
               rsp_in.slot_used  = '0;
               state_in          = ST_IDLE;
            end else begin
               scan_clear = 1'b1;
               idx_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // rotate the ring one place; after a full turn every slot is home
            shift_en = 1'b1;
            idx_in   = idx_ff + IW'(1);
            if (idx_ff == IW'(PEER_SLOTS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            wr_en = 1'b1;
            if (!match.found && used_ff < UW'(PEER_SLOTS)) begin
               used_in = used_ff + UW'(1);
            end
            if (!p_reject) begin
               gcount_in = gcount_ff + COUNT_W'(1);
            end
            rsp_valid_in     = 1'b1;
            rsp_in.verdict   = p_reject ? VERDICT_PEER_REJ : VERDICT_ACCEPT;
            rsp_in.slot_used = SLOT_OUT_W'(wr_idx);
            state_in         = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         glim_ff      <= COUNT_W'(100);
         glen_ff      <= LEN_W'(1000);
         plim_ff      <= COUNT_W'(8);
         plen_ff      <= LEN_W'(60000);
         gstart_ff    <= '0;
         gcount_ff    <= '0;
         used_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         glim_ff      <= glim_in;
         glen_ff      <= glen_in;
         plim_ff      <= plim_in;
         plen_ff      <= plen_in;
         gstart_ff    <= gstart_in;
         gcount_ff    <= gcount_in;
         used_ff      <= used_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/pkfwrl_cell.sv =====
module pkfwrl_cell
   import pkfwrl_pkg::*;
(
   input  logic     clock,
   input  logic     shift_en,
   input  slot_type shift_in,
   input  logic     wr_en,
   input  slot_type wr_data,
   output slot_type slot_q
);

   slot_type slot_ff;
   slot_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (wr_en) begin
         slot_in = wr_data;
      end else if (shift_en) begin
         slot_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_q = slot_ff;

endmodule

// ===== rtl/core/pkfwrl_scan.sv =====
module pkfwrl_scan
   import pkfwrl_pkg::*;
#(
   parameter int IW = 6
)
(
   input  logic          clock,
   input  logic          clear,
   input  logic          step,
   input  logic          live,
   input  logic [IW-1:0] head_idx,
   input  slot_type      head,
   input  req_type       req,
   output match_type     match,
   output logic [IW-1:0] match_idx,
   output logic [IW-1:0] evict_idx
);

   match_type         match_ff, match_in;
   logic [IW-1:0]     match_idx_ff, match_idx_in;
   logic [IW-1:0]     evict_idx_ff, evict_idx_in;
   logic [TIME_W-1:0] evict_ts_ff, evict_ts_in;
   logic              have_old_ff, have_old_in;
   logic              hit;

   assign hit = head.key_w0 == req.peer_word_0 && head.key_w1 == req.peer_word_1 &&
                head.key_w2 == req.peer_word_2 && head.key_w3 == req.peer_word_3;

   always_comb begin
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      evict_idx_in = evict_idx_ff;
      evict_ts_in  = evict_ts_ff;
      have_old_in  = have_old_ff;
      if (clear) begin
         match_in    = '0;
         have_old_in = 1'b0;
      end else if (step && live && !match_ff.found) begin
         if (hit) begin
            match_in.found     = 1'b1;
            match_in.win_start = head.win_start;
            match_in.count     = head.count;
            match_idx_in       = head_idx;
         end else if (!have_old_ff || head.win_start < evict_ts_ff) begin
            // strict compare keeps the lowest index on ties
            have_old_in  = 1'b1;
            evict_ts_in  = head.win_start;
            evict_idx_in = head_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      evict_idx_ff <= evict_idx_in;
      evict_ts_ff  <= evict_ts_in;
      have_old_ff  <= have_old_in;
   end

   assign match     = match_ff;
   assign match_idx = match_idx_ff;
   assign evict_idx = evict_idx_ff;

endmodule

// ===== rtl/core/pkfwrl_checker.sv =====
module pkfwrl_checker
   import pkfwrl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request transfer did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.verdict != 2'd3)
      else $error("undefined verdict code");

   a_global_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict == VERDICT_GLOBAL_REJ |-> rsp_data.slot_used == '0)
      else $error("global reject with nonzero slot");

   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result strobe outside end of a busy period");

endmodule

bind per_key_fixed_window_rate_limiter pkfwrl_checker u_pkfwrl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== sim/pkfwrl_checker.sv =====
`timescale 1ns / 1ps
module pkfwrl_scoreboard
   import pkfwrl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   output int                   fail_count,
   output int                   pending,
   output int                   verdict_seen [3]
);

   localparam int SLOTS = 64;

   logic [COUNT_W-1:0] lim_global, lim_peer;
   logic [LEN_W-1:0]   len_global, len_peer;
   logic [TIME_W-1:0]  gwin_start;
   logic [COUNT_W-1:0] gcount;
   int                 occupied;
   logic [KEY_W-1:0]   key0 [SLOTS];
   logic [KEY_W-1:0]   key1 [SLOTS];
   logic [KEY_W-1:0]   key2 [SLOTS];
   logic [KEY_W-1:0]   key3 [SLOTS];
   logic [TIME_W-1:0]  win_start [SLOTS];
   logic [COUNT_W-1:0] count [SLOTS];
   rsp_type            verdict_q [$];

   function automatic rsp_type admit(req_type r);
      rsp_type   res;
      int        slot, oldest;
      bit        hit;
      logic [TIME_W:0] stale_ts;
      res = '0;
      slot = 0;
      oldest = 0;
      hit = 0;
      stale_ts = {1'b1, {TIME_W{1'b0}}};
      if (TIME_W'(r.now_ms - gwin_start) >= len_global) begin
         gwin_start = r.now_ms;
         gcount = '0;
      end
      if (gcount >= lim_global) begin
         res.verdict = VERDICT_GLOBAL_REJ;
         return res;
      end
      for (int i = 0; i < occupied; i++) begin
         if (key0[i] == r.peer_word_0 && key1[i] == r.peer_word_1 &&
             key2[i] == r.peer_word_2 && key3[i] == r.peer_word_3) begin
            slot = i;
            hit = 1;
            break;
         end
         if ({1'b0, win_start[i]} < stale_ts) begin
            stale_ts = {1'b0, win_start[i]};
            oldest = i;
         end
      end
      if (!hit) begin
         if (occupied < SLOTS) begin
            slot = occupied;
            occupied++;
         end else begin
            slot = oldest;
         end
         key0[slot] = r.peer_word_0;
         key1[slot] = r.peer_word_1;
         key2[slot] = r.peer_word_2;
         key3[slot] = r.peer_word_3;
         count[slot] = '0;
         win_start[slot] = r.now_ms;
      end
      if (TIME_W'(r.now_ms - win_start[slot]) >= len_peer) begin
         win_start[slot] = r.now_ms;
         count[slot] = '0;
      end
      res.slot_used = SLOT_OUT_W'(slot);
      if (count[slot] >= lim_peer) begin
         res.verdict = VERDICT_PEER_REJ;
         return res;
      end
      count[slot]++;
      gcount++;
      res.verdict = VERDICT_ACCEPT;
      return res;
   endfunction

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   assign pending = verdict_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         lim_global <= 16'd100;
         len_global <= 32'd1000;
         lim_peer   <= 16'd8;
         len_peer   <= 32'd60000;
         gwin_start = '0;
         gcount = '0;
         occupied = 0;
         verdict_q.delete();
         fail_count = 0;
         verdict_seen <= '{0, 0, 0};
      end else begin
         if (rsp_valid) begin
            if (verdict_q.size() == 0) begin
               report("result with nothing expected");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.verdict != want.verdict)
                  report($sformatf("verdict %0d, expected %0d",
                                   rsp_data.verdict, want.verdict));
               if (rsp_data.slot_used != want.slot_used)
                  report($sformatf("slot %0d, expected %0d",
                                   rsp_data.slot_used, want.slot_used));
               if (want.verdict < 3)
                  verdict_seen[want.verdict] <= verdict_seen[want.verdict] + 1;
            end
         end
         if (start && !busy)
            verdict_q.push_back(admit(req_data));
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_GLOBAL_LIMIT: lim_global <= csr_data[COUNT_W-1:0];
               CSR_GLOBAL_LEN:   len_global <= csr_data;
               CSR_PEER_LIMIT:   lim_peer   <= csr_data[COUNT_W-1:0];
               CSR_PEER_LEN:     len_peer   <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import pkfwrl_pkg::*;

   localparam int  SLOT_LAT = 66;
   localparam longint LIMIT = 1_500_000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;
   int                   fail_count, pending;
   int                   verdict_seen [3];
   longint               cycle = 0;
   int                   sent = 0;
   int                   idle_pct = 0;
   logic [KEY_W-1:0]     key_pool [16][4];
   logic [TIME_W-1:0]    clock_ms = '0;

   always #5 clock = ~clock;

   per_key_fixed_window_rate_limiter i_dut (.*);

   pkfwrl_scoreboard i_chk (.*);

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("timeout after %0d cycles", cycle);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // wait until the block is quiet before touching registers
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (SLOT_LAT + 4) @(negedge clock);
   endtask

   // hold start for one cycle while busy is low: exactly one transfer
   task automatic send(req_type r);
      while (busy) @(negedge clock);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      req_data <= r;
      start    <= 1;
      @(negedge clock);
      start <= 0;
      sent++;
   endtask

   function automatic req_type make_req(logic [TIME_W-1:0] t, int k);
      req_type r;
      r.now_ms = t;
      r.peer_word_0 = key_pool[k][0];
      r.peer_word_1 = key_pool[k][1];
      r.peer_word_2 = key_pool[k][2];
      r.peer_word_3 = key_pool[k][3];
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // run one phase of traffic: mostly peers from a pool of the given size, some fresh random keys and times
   task automatic traffic(int n, int peers, int max_step);
      req_type r;
      for (int i = 0; i < n; i++) begin
         clock_ms = clock_ms + TIME_W'($urandom_range(max_step));
         if ($urandom_range(9) == 0)
            r = '{TIME_W'(rand64()), rand64(), rand64(), rand64(), rand64()};
         else if ($urandom_range(19) == 0)
            r = '{TIME_W'(rand64()), rand64(), rand64(), rand64(), rand64()};
         else begin
            r = make_req(clock_ms, $urandom_range(peers - 1));
            // flip one bit of key word 2: near miss
            if ($urandom_range(15) == 0) r.peer_word_2 ^= 64'h1 << $urandom_range(63);
         end
         send(r);
      end
   endtask

   initial begin
      for (int k = 0; k < 16; k++)
         for (int w = 0; w < 4; w++)
            key_pool[k][w] = rand64();
      key_pool[0] = '{64'h0, 64'h0, 64'h0, 64'h0};
      key_pool[1] = '{'1, '1, '1, '1};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset settings, extremes of time and keys, limits and window lengths at zero and maximum
      send(make_req(48'd0, 0));
      send(make_req('1, 1));
      send(make_req(48'd5, 1));
      for (int i = 0; i < 10; i++) send(make_req(48'd10, 2));
      drain();
      csr_write(CSR_GLOBAL_LIMIT, 32'd0);
      send(make_req(48'd20, 3));
      send(make_req(48'd4000, 3));
      drain();
      csr_write(CSR_GLOBAL_LIMIT, 32'hFFFF);
      csr_write(CSR_GLOBAL_LEN, 32'd0);
      csr_write(CSR_PEER_LIMIT, 32'd0);
      send(make_req(48'd30, 4));
      drain();
      csr_write(CSR_PEER_LIMIT, 32'd2);
      csr_write(CSR_PEER_LEN, 32'd0);
      for (int i = 0; i < 3; i++) send(make_req(48'd40, 5));
      drain();
      csr_write(CSR_GLOBAL_LEN, 32'hFFFF_FFFF);
      csr_write(CSR_PEER_LEN, 32'hFFFF_FFFF);
      for (int i = 0; i < 3; i++) send(make_req(48'hFFFF_FFFF_FFF0, 6));
      drain();

      // random phases: fresh random keys throughout for eviction pressure, peer pools of 8 to 16, varied settings
      csr_write(CSR_GLOBAL_LIMIT, 32'd50);
      csr_write(CSR_GLOBAL_LEN, 32'd200);
      csr_write(CSR_PEER_LIMIT, 32'd3);
      csr_write(CSR_PEER_LEN, 32'd500);
      idle_pct = 0;
      traffic(450, 16, 20);
      idle_pct = 63;
      traffic(400, 8, 5);
      drain();
      csr_write(CSR_GLOBAL_LIMIT, 32'd20);
      csr_write(CSR_GLOBAL_LEN, 32'd1);
      csr_write(CSR_PEER_LIMIT, 32'hFFFF);
      csr_write(CSR_PEER_LEN, 32'd1);
      idle_pct = 26;
      traffic(300, 16, 2);
      drain();
      csr_write(CSR_GLOBAL_LIMIT, 32'd100);
      csr_write(CSR_GLOBAL_LEN, 32'd1000);
      csr_write(CSR_PEER_LIMIT, 32'd8);
      csr_write(CSR_PEER_LEN, 32'd60000);
      idle_pct = 0;
      traffic(575, 12, 30);

      drain();
      $display("%0d requests sent: %0d accepted, %0d global rejects, %0d peer rejects",
               sent, verdict_seen[0], verdict_seen[1], verdict_seen[2]);
      $display("covered limits and window lengths at both extremes, evictions and near-miss keys");
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== per_key_fixed_window_rate_limiter.f =====
rtl/core/pkfwrl_pkg.sv
rtl/core/pkfwrl_cell.sv
rtl/core/pkfwrl_scan.sv
rtl/core/per_key_fixed_window_rate_limiter.sv
rtl/core/pkfwrl_checker.sv
sim/pkfwrl_checker.sv
sim/tb.sv
